### rtl/gmf_pkg.sv
// ----------------------------------------------------------------------------
// gmf_pkg
// Shared constants, command codes and sequencer states of the grouped medoid
// finder.
// ----------------------------------------------------------------------------
`default_nettype none

package gmf_pkg;

	// Default sizing of the block.
	localparam int OBS_DEF    = 256;
	localparam int GROUPS_DEF = 64;
	localparam int DIST_W_DEF = 32;

	// Fixed field widths of the channels and the count register.
	localparam int OP_W      = 2;
	localparam int POS_W     = 15;
	localparam int IN_DIST_W = 32;
	localparam int LABEL_W   = 6;
	localparam int MEDOID_W  = 9;
	localparam int COUNT_W   = 9;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

	typedef enum logic [OP_W-1:0] {
		OP_WR_DIST  = 2'd0,
		OP_WR_LABEL = 2'd1,
		OP_RUN      = 2'd2
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_END,
		ST_GROUP,
		ST_ROW,
		ST_ROW_CHK,
		ST_COL,
		ST_COL_END,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

### rtl/gmf_req_if.sv
// ----------------------------------------------------------------------------
// gmf_req_if
// Command channel: distance writes, label writes and run commands.
// ----------------------------------------------------------------------------
`default_nettype none

interface gmf_req_if;
	import gmf_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      operation;
	logic [POS_W-1:0]     position;
	logic [IN_DIST_W-1:0] distance;
	logic [LABEL_W-1:0]   group_label;

	modport source (output valid, output operation, output position, output distance,
		output group_label, input ready);
	modport sink (input valid, input operation, input position, input distance,
		input group_label, output ready);
endinterface

`default_nettype wire

### rtl/gmf_rsp_if.sv
// ----------------------------------------------------------------------------
// gmf_rsp_if
// Result channel: one beat per group present in a run.
// ----------------------------------------------------------------------------
`default_nettype none

interface gmf_rsp_if;
	import gmf_pkg::*;

	logic                valid;
	logic                ready;
	logic [LABEL_W-1:0]  group_id;
	logic [MEDOID_W-1:0] medoid;
	logic                last_group;

	modport source (output valid, output group_id, output medoid, output last_group,
		input ready);
	modport sink (input valid, input group_id, input medoid, input last_group,
		output ready);
endinterface

`default_nettype wire

### rtl/gmf_dist_mem.sv
// ----------------------------------------------------------------------------
// gmf_dist_mem
// Condensed pair distance store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gmf_dist_mem #(
	parameter int DEPTH = 32640,
	parameter int WIDTH = 32,
	parameter int AW    = 15
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

`default_nettype wire

### rtl/gmf_label_mem.sv
// ----------------------------------------------------------------------------
// gmf_label_mem
// Group label store with one valid bit per entry, so that every label reads
// as zero after reset until it is written.
// ----------------------------------------------------------------------------
`default_nettype none

module gmf_label_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        we,
	input  wire logic [AW-1:0]               waddr,
	input  wire logic [gmf_pkg::LABEL_W-1:0] wdata,
	input  wire logic [AW-1:0]               raddr,
	output logic      [gmf_pkg::LABEL_W-1:0] rdata
);
	import gmf_pkg::*;

	logic [LABEL_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]   vld_q;
	logic [LABEL_W-1:0] rd_q;
	logic               rd_vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rd_vld_q <= vld_q[raddr];
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;
endmodule

`default_nettype wire

### rtl/grouped_medoid_finder_top.sv
// ----------------------------------------------------------------------------
// grouped_medoid_finder_top
// Per-group medoid search over a condensed pairwise distance store.
// ----------------------------------------------------------------------------
// The req channel carries one command per beat: a distance write, a label write
// or a run. Ready stays high between runs, so the stores load at one beat per
// cycle. cfg_wr_en/cfg_wr_data set the observation count n; the user must see
// that they are written only while no run is in progress, as the block itself
// does not enforce it. A run first scans the n labels, then steps through the
// group labels, one per cycle while a label is absent. For each present group
// every observation has its label checked in ST_ROW and ST_ROW_CHK, and every
// member then reads one label and one distance per cycle in ST_COL across all
// n observations before ST_COL_END. Each store has a single read port.
// Results leave through an output register, one beat per present group in
// ascending label order, with last_group on the final beat. When the receiver
// stalls, the run waits at the end of the next group until the register frees.
// Reset clears all labels to zero and sets n to 256; distances are undefined
// until written.
// ----------------------------------------------------------------------------
`default_nettype none

module grouped_medoid_finder_top #(
	parameter int MAX_OBSERVATIONS = gmf_pkg::OBS_DEF,
	parameter int MAX_GROUPS       = gmf_pkg::GROUPS_DEF,
	parameter int DISTANCE_WIDTH   = gmf_pkg::DIST_W_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [gmf_pkg::COUNT_W-1:0] cfg_wr_data,
	gmf_req_if.sink                          req,
	gmf_rsp_if.source                        rsp
);
	import gmf_pkg::*;

	localparam int IW         = $clog2(MAX_OBSERVATIONS);
	localparam int NW         = $clog2(MAX_OBSERVATIONS + 1);
	localparam int PAIR_DEPTH = (MAX_OBSERVATIONS * (MAX_OBSERVATIONS - 1)) / 2;
	localparam int PW         = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
	localparam int SUM_W      = DISTANCE_WIDTH + IW;
	localparam int GW         = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam logic [LABEL_W-1:0] G_TOP = LABEL_W'(MAX_GROUPS - 1);

	state_t state_q, state_d;

	logic [COUNT_W-1:0] cfg_q;
	logic [NW-1:0]      n_eff;
	logic [IW-1:0]      n_m1;

	logic [IW-1:0]         i_q, j_q;
	logic [LABEL_W-1:0]    g_q, last_q;
	logic [MAX_GROUPS-1:0] present_q;
	logic [PW:0]           rowj_q;
	logic [PW:0]           rowi_q;
	logic [PW:0]           row_base;
	logic                  lv_s1, self_s1;
	logic [SUM_W-1:0]      sum_q, best_sum_q, addend, sum_fin;
	logic [NW-1:0]         best_mem_q;
	logic [NW-1:0]         row_step;
	logic [IW-1:0]         col_off;

	logic                out_v_q;
	logic [LABEL_W-1:0]  out_g_q;
	logic [MEDOID_W-1:0] out_m_q;
	logic                out_l_q;

	logic                      lab_we;
	logic [IW-1:0]             lab_raddr;
	logic [LABEL_W-1:0]        lab_rdata;
	logic                      dist_we;
	logic [PW-1:0]             dist_raddr;
	logic [DISTANCE_WIDTH-1:0] dist_rdata;

	logic in_acc, is_run, emit_load, i_last, j_last, member_hit, better;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= COUNT_RESET;
		end else if (cfg_wr_en) begin
			cfg_q <= cfg_wr_data;
		end
	end

	// A count of zero acts as one; a count above the store size is clamped.
	always_comb begin
		if (cfg_q == '0) begin
			n_eff = NW'(1);
		end else if (32'(cfg_q) > MAX_OBSERVATIONS) begin
			n_eff = NW'(MAX_OBSERVATIONS);
		end else begin
			n_eff = NW'(cfg_q);
		end
	end

	assign n_m1 = IW'(n_eff - NW'(1));

	// ---------------------------------------------------------------- stores
	assign in_acc = req.valid && req.ready;
	assign is_run = (req.operation == OP_RUN);

	always_comb begin
		lab_we  = 1'b0;
		dist_we = 1'b0;
		if (in_acc) begin
			unique case (req.operation)
				OP_WR_DIST: begin
					dist_we = (32'(req.position) < PAIR_DEPTH);
				end
				OP_WR_LABEL: begin
					lab_we = (32'(req.position) < MAX_OBSERVATIONS) &&
						(32'(req.group_label) < MAX_GROUPS);
				end
				default: begin
				end
			endcase
		end
	end

	// Pair address for j against the current member i: the row start of the
	// smaller index plus the offset of the larger one inside that row. rowj_q
	// tracks the row start of j, and rowi_q keeps that of i once j has passed it.
	assign col_off    = (j_q < i_q) ? (i_q - j_q - IW'(1)) : (j_q - i_q - IW'(1));
	assign row_base   = (j_q < i_q) ? rowj_q : rowi_q;
	assign dist_raddr = PW'(row_base + (PW + 1)'(col_off));
	assign row_step   = n_eff - NW'(j_q) - NW'(1);
	assign lab_raddr  = (state_q == ST_COL) ? j_q : i_q;

	gmf_label_mem #(
		.DEPTH(MAX_OBSERVATIONS),
		.AW   (IW)
	) u_label_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (lab_we),
		.waddr (IW'(req.position)),
		.wdata (req.group_label),
		.raddr (lab_raddr),
		.rdata (lab_rdata)
	);

	gmf_dist_mem #(
		.DEPTH(PAIR_DEPTH),
		.WIDTH(DISTANCE_WIDTH),
		.AW   (PW)
	) u_dist_mem (
		.clk  (clk),
		.we   (dist_we),
		.waddr(PW'(req.position)),
		.wdata(DISTANCE_WIDTH'(req.distance)),
		.raddr(dist_raddr),
		.rdata(dist_rdata)
	);

	// ------------------------------------------------------------- datapath
	assign i_last     = (i_q == n_m1);
	assign j_last     = (j_q == n_m1);
	assign member_hit = (lab_rdata == g_q);
	assign addend     = (lv_s1 && member_hit && !self_s1) ? SUM_W'(dist_rdata) : '0;
	assign sum_fin    = sum_q + addend;
	assign better     = (sum_fin < best_sum_q);
	assign emit_load  = (state_q == ST_EMIT) && (!out_v_q || rsp.ready);

	// -------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && is_run) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (i_last) begin
					state_d = ST_SCAN_END;
				end
			end
			ST_SCAN_END: begin
				state_d = ST_GROUP;
			end
			ST_GROUP: begin
				if (present_q[g_q[GW-1:0]]) begin
					state_d = ST_ROW;
				end else if (g_q == G_TOP) begin
					state_d = ST_IDLE;
				end
			end
			ST_ROW: begin
				state_d = ST_ROW_CHK;
			end
			ST_ROW_CHK: begin
				if (member_hit) begin
					state_d = ST_COL;
				end else if (i_last) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_ROW;
				end
			end
			ST_COL: begin
				if (j_last) begin
					state_d = ST_COL_END;
				end
			end
			ST_COL_END: begin
				state_d = i_last ? ST_EMIT : ST_ROW;
			end
			ST_EMIT: begin
				if (emit_load) begin
					state_d = (g_q == last_q) ? ST_IDLE : ST_GROUP;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q        <= '0;
			j_q        <= '0;
			g_q        <= '0;
			last_q     <= '0;
			present_q  <= '0;
			lv_s1      <= 1'b0;
			best_sum_q <= '1;
			best_mem_q <= '0;
		end else begin
			lv_s1 <= (state_q == ST_SCAN) || (state_q == ST_COL);

			if (state_q == ST_IDLE && in_acc && is_run) begin
				i_q       <= '0;
				present_q <= '0;
				last_q    <= '0;
			end

			// Label scan: the read data of the previous cycle marks its group.
			if ((state_q == ST_SCAN || state_q == ST_SCAN_END) && lv_s1) begin
				present_q[lab_rdata[GW-1:0]] <= 1'b1;
				if (lab_rdata > last_q) begin
					last_q <= lab_rdata;
				end
			end
			if (state_q == ST_SCAN && !i_last) begin
				i_q <= i_q + IW'(1);
			end
			if (state_q == ST_SCAN_END) begin
				g_q <= '0;
			end

			if (state_q == ST_GROUP) begin
				if (present_q[g_q[GW-1:0]]) begin
					best_sum_q <= '1;
					best_mem_q <= '0;
					i_q        <= '0;
				end else begin
					g_q <= g_q + LABEL_W'(1);
				end
			end

			if (state_q == ST_ROW_CHK) begin
				if (member_hit) begin
					j_q <= '0;
				end else if (!i_last) begin
					i_q <= i_q + IW'(1);
				end
			end

			if (state_q == ST_COL && !j_last) begin
				j_q <= j_q + IW'(1);
			end

			if (state_q == ST_COL_END) begin
				if (better) begin
					best_sum_q <= sum_fin;
					best_mem_q <= NW'(i_q) + NW'(1);
				end
				if (!i_last) begin
					i_q <= i_q + IW'(1);
				end
			end

			if (emit_load && g_q != last_q) begin
				g_q <= g_q + LABEL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		self_s1 <= (j_q == i_q);
		if (state_q == ST_ROW_CHK) begin
			rowj_q <= '0;
			sum_q  <= '0;
		end
		if (state_q == ST_COL) begin
			rowj_q <= rowj_q + (PW + 1)'(row_step);
		end
		if (state_q == ST_COL && j_q == i_q) begin
			rowi_q <= rowj_q;
		end
		if (state_q == ST_COL || state_q == ST_COL_END) begin
			sum_q <= sum_fin;
		end
	end

	// ---------------------------------------------------------- result output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (emit_load) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_g_q <= g_q;
			out_m_q <= MEDOID_W'(best_mem_q);
			out_l_q <= (g_q == last_q);
		end
	end

	assign rsp.valid      = out_v_q;
	assign rsp.group_id   = out_g_q;
	assign rsp.medoid     = out_m_q;
	assign rsp.last_group = out_l_q;

	// ------------------------------------------------------------ assertions
	// Every emitted group was seen in the scan and found a member.
	a_emit_present: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> present_q[g_q[GW-1:0]])
		else $error("emitting a group that the scan did not find");

	a_emit_member: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> best_mem_q != '0)
		else $error("group finished without a medoid");

	// The group walk never passes the highest present label.
	a_group_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_GROUP |-> g_q <= last_q)
		else $error("group walk passed the last present group");

	// A result beat only appears after the sequencer offered it.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(state_q == ST_EMIT))
		else $error("result beat without a finished group");
endmodule

`default_nettype wire
